### rtl/core/tod_pkg.sv
package tod_pkg;

   // Fixed field widths
   localparam int TIME_W    = 32;
   localparam int DWELL_W   = 16;
   localparam int CSR_IDX_W = 4;

   // Register indexes; windows occupy CSR_WINDOW_BASE onward, one per orientation
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_MS    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 4'd2;

   typedef logic [TIME_W-1:0]    stamp_type;
   typedef logic [DWELL_W-1:0]   dwell_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

endpackage

### rtl/core/tod_req_if.sv
interface tod_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_x;
   logic [SAMPLE_BITS-1:0] sample_y;
   logic [31:0]            time_ms;

   modport source (output valid, sample_x, sample_y, time_ms, input ready);
   modport sink   (input valid, sample_x, sample_y, time_ms, output ready);
endinterface

### rtl/core/tod_rsp_if.sv
interface tod_rsp_if #(
   parameter int ORIENT_W = 2
);
   logic                valid;
   logic                ready;
   logic                rotate_now;
   logic [ORIENT_W-1:0] rotate_to;
   logic [ORIENT_W-1:0] candidate;
   logic                timer_restarted;

   modport source (output valid, rotate_now, rotate_to, candidate, timer_restarted,
                   input ready);
   modport sink   (input valid, rotate_now, rotate_to, candidate, timer_restarted,
                   output ready);
endinterface

### rtl/core/tod_csr_if.sv
interface tod_csr_if #(
   parameter int DATA_W = 41
);
   logic              valid;
   logic              ready;
   logic [3:0]        index;
   logic [DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/tod_csr.sv
module tod_csr #(
   parameter int NUM_ORIENTS = 4,
   parameter int WIN_W       = 41
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  tod_pkg::csr_index_type  wr_index,
   input  logic [WIN_W-1:0]        wr_data,
   output logic                    auto_enable,
   output tod_pkg::dwell_type      dwell_ms,
   output logic [WIN_W-1:0]        windows [NUM_ORIENTS]
);
   import tod_pkg::*;

   localparam int OW = (NUM_ORIENTS > 1) ? $clog2(NUM_ORIENTS) : 1;

   logic              auto_ff, auto_in;
   dwell_type         dwell_ff, dwell_in;
   logic [WIN_W-1:0]  win_ff [NUM_ORIENTS];
   logic              win_we;
   csr_index_type     win_off;

   assign win_off = wr_index - CSR_WINDOW_BASE;

   always_comb begin
      auto_in  = auto_ff;
      dwell_in = dwell_ff;
      win_we   = 1'b0;
      if (wr_en) begin
         unique case (wr_index)
            CSR_AUTO_ENABLE: auto_in  = wr_data[0];
            CSR_DWELL_MS:    dwell_in = wr_data[DWELL_W-1:0];
            default: begin
               win_we = (wr_index >= CSR_WINDOW_BASE) &&
                        ({1'b0, wr_index} < (5'(CSR_WINDOW_BASE) + 5'(NUM_ORIENTS)));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff  <= 1'b0;
         dwell_ff <= '0;
         for (int k = 0; k < NUM_ORIENTS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         auto_ff  <= auto_in;
         dwell_ff <= dwell_in;
         if (win_we) begin
            win_ff[win_off[OW-1:0]] <= wr_data;
         end
      end
   end

   assign auto_enable = auto_ff;
   assign dwell_ms    = dwell_ff;
   assign windows     = win_ff;

endmodule

### rtl/core/tod_win.sv
module tod_win #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic [4*SAMPLE_BITS:0]   window,
   input  logic [SAMPLE_BITS-1:0]   x,
   input  logic [SAMPLE_BITS-1:0]   y,
   output logic                     hit
);
   localparam int S = SAMPLE_BITS;

   logic [S-1:0] min_x, max_x, min_y, max_y;
   logic         en;

   assign min_x = window[S-1:0];
   assign max_x = window[2*S-1:S];
   assign min_y = window[3*S-1:2*S];
   assign max_y = window[4*S-1:3*S];
   assign en    = window[4*S];

   // an inverted window simply never matches
   assign hit = en && (min_x <= x) && (x <= max_x) && (min_y <= y) && (y <= max_y);

endmodule

### rtl/core/tod_decide.sv
module tod_decide #(
   parameter int NUM_ORIENTS = 4,
   parameter int OW          = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   auto_enable,
   input  tod_pkg::dwell_type     dwell_ms,
   input  tod_pkg::stamp_type     now,
   input  logic [NUM_ORIENTS-1:0] hit,
   output logic                   rotate_now,
   output logic [OW-1:0]          rotate_to,
   output logic [OW-1:0]          candidate,
   output logic                   timer_restarted
);
   import tod_pkg::*;

   logic [OW-1:0] cand_ff, cand_in;
   stamp_type     change_time_ff, change_time_in;
   stamp_type     elapsed;
   logic          long_enough;
   logic          hit_below;
   logic          hit_other;
   logic [OW-1:0] top_hit;

   // Sequential window walk collapses to: rotate only if the held candidate's
   // window hits and nothing earlier stole it; any other hit restarts the timer
   // and the last hitting window ends up as the candidate.
   always_comb begin
      hit_below = 1'b0;
      hit_other = 1'b0;
      top_hit   = '0;
      for (int k = 0; k < NUM_ORIENTS; k++) begin
         if (hit[k]) begin
            top_hit = OW'(k);
            if (OW'(k) < cand_ff) hit_below = 1'b1;
            if (OW'(k) != cand_ff) hit_other = 1'b1;
         end
      end
   end

   assign elapsed     = now - change_time_ff;
   assign long_enough = elapsed > TIME_W'(dwell_ms);

   assign rotate_now      = auto_enable && hit[cand_ff] && !hit_below && long_enough;
   assign rotate_to       = rotate_now ? cand_ff : '0;
   assign timer_restarted = auto_enable && hit_other;

   assign cand_in        = (fire && timer_restarted) ? top_hit : cand_ff;
   assign change_time_in = (fire && timer_restarted) ? now : change_time_ff;
   assign candidate      = timer_restarted ? top_hit : cand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff        <= '0;
         change_time_ff <= '0;
      end else begin
         cand_ff        <= cand_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

### rtl/core/tilt_orientation_dwell_detector_core.sv
// Tilt orientation dwell detector. Each request carries one accelerometer
// sample (x, y) and a free-running millisecond timestamp; each produces exactly
// one response in request order. With auto_enable set, every enabled window
// that contains the sample is considered in index order: the held candidate
// signals rotate_now once it has persisted strictly longer than dwell_ms
// (32-bit wrapping elapsed time), and a hit on any other window makes it the
// new candidate and restarts the dwell timer. Timing: a request is registered
// on acceptance, evaluated from that register by the window compares, one
// 32-bit subtract and compare, and lands in the response register; one
// request can be accepted every cycle while responses are taken. The response
// register is freed as it is taken, so a full pipeline keeps streaming while
// rsp_if.ready is high. Write CSRs only while no requests are in flight.
module tilt_orientation_dwell_detector_core #(
   parameter int NUM_ORIENTS = 4,
   parameter int SAMPLE_BITS = 10
) (
   input logic  clock,
   input logic  reset,
   tod_req_if.sink   req_if,
   tod_rsp_if.source rsp_if,
   tod_csr_if.sink   csr_if
);
   import tod_pkg::*;

   localparam int OW    = (NUM_ORIENTS > 1) ? $clog2(NUM_ORIENTS) : 1;
   localparam int WIN_W = 4 * SAMPLE_BITS + 1;

   // configuration
   logic             auto_enable;
   dwell_type        dwell_ms;
   logic [WIN_W-1:0] windows [NUM_ORIENTS];

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] x_ff, y_ff;
   stamp_type              t_ff;

   // response stage
   logic          out_valid_ff, out_valid_in;
   logic          rot_now_ff;
   logic [OW-1:0] rot_to_ff, cand_ff;
   logic          restart_ff;

   logic                   out_load;
   logic                   s1_fire;
   logic                   req_take;
   logic [NUM_ORIENTS-1:0] hit;
   logic                   rot_now;
   logic [OW-1:0]          rot_to;
   logic [OW-1:0]          cand;
   logic                   restart;

   assign csr_if.ready = 1'b1;

   tod_csr #(
      .NUM_ORIENTS (NUM_ORIENTS),
      .WIN_W       (WIN_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_if.valid),
      .wr_index    (csr_if.index),
      .wr_data     (csr_if.data[WIN_W-1:0]),
      .auto_enable (auto_enable),
      .dwell_ms    (dwell_ms),
      .windows     (windows)
   );

   // handshake: response register frees when empty or being taken
   assign out_load     = !out_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && out_load;
   assign req_if.ready = !s1_valid_ff || out_load;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_load);
   assign out_valid_in = s1_fire || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_if.sample_x;
         y_ff <= req_if.sample_y;
         t_ff <= req_if.time_ms;
      end
      if (s1_fire) begin
         rot_now_ff <= rot_now;
         rot_to_ff  <= rot_to;
         cand_ff    <= cand;
         restart_ff <= restart;
      end
   end

   // one window compare per orientation
   for (genvar g = 0; g < NUM_ORIENTS; g++) begin : g_win
      tod_win #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_win (
         .window (windows[g]),
         .x      (x_ff),
         .y      (y_ff),
         .hit    (hit[g])
      );
   end

   // candidate state and dwell timing; state commits when the request moves on
   tod_decide #(
      .NUM_ORIENTS (NUM_ORIENTS),
      .OW          (OW)
   ) u_decide (
      .clock           (clock),
      .reset           (reset),
      .fire            (s1_fire),
      .auto_enable     (auto_enable),
      .dwell_ms        (dwell_ms),
      .now             (t_ff),
      .hit             (hit),
      .rotate_now      (rot_now),
      .rotate_to       (rot_to),
      .candidate       (cand),
      .timer_restarted (restart)
   );

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.rotate_now      = rot_now_ff;
   assign rsp_if.rotate_to       = rot_to_ff;
   assign rsp_if.candidate       = cand_ff;
   assign rsp_if.timer_restarted = restart_ff;

`ifndef NO_ASSERTIONS
   // no rotation reports orientation zero
   a_rot_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.rotate_now |-> rsp_if.rotate_to == '0)
      else $error("rotate_to nonzero without rotate_now");

   // a rotate without a restart leaves the rotated-to orientation as candidate
   a_rot_cand: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.rotate_now && !rsp_if.timer_restarted
      |-> rsp_if.rotate_to == rsp_if.candidate)
      else $error("rotate target differs from held candidate");

   // an accepted request always occupies the input stage next cycle
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted request lost");

   // a rotation can only be signalled while detection is enabled
   a_rot_auto: assert property (@(posedge clock) disable iff (reset)
      s1_fire && rot_now |-> auto_enable)
      else $error("rotate while auto mode off");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the tilt orientation dwell detector.
// A short directed part comes first. Random phases follow, and each phase
// reprograms the registers while the block is idle. A scoreboard class
// predicts one verdict per accepted request and checks the responses in order.
module tb_top;
   import tod_pkg::*;

   localparam int ORIENTS     = 4;
   localparam int SBITS       = 10;
   localparam int WIN_W       = 4 * SBITS + 1;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   // first index past the window registers; writes there must be ignored
   localparam csr_index_type CSR_FIRST_SPARE = csr_index_type'(CSR_WINDOW_BASE + ORIENTS);

   typedef logic [SBITS-1:0] axis_type;
   typedef logic [WIN_W-1:0] window_type;

   localparam axis_type   AXIS_MAX = '1;
   localparam window_type AUTO_ON  = window_type'(1);
   localparam window_type AUTO_OFF = window_type'(0);

   typedef enum logic [1:0] {
      LANDSCAPE,
      PORTRAIT,
      LANDSCAPE_FLIP,
      PORTRAIT_FLIP
   } orient_type;

   typedef enum int {
      RX_STREAM,
      RX_COIN,
      RX_ONE_IN_FOUR,
      RX_RARE_STALL
   } rx_mode_type;

   typedef struct packed {
      logic       rotate_now;
      logic [1:0] rotate_to;
      logic [1:0] candidate;
      logic       timer_restarted;
   } verdict_type;

   // Scoreboard. It holds its own copy of the registers and the candidate
   // state, and it queues one expected verdict per accepted request.
   class dwell_checker;
      bit          auto_on;
      dwell_type   dwell;
      window_type  windows[ORIENTS];
      logic [1:0]  held;
      stamp_type   change_at;
      verdict_type due_verdicts[$];
      int          mismatches;

      function new();
         auto_on = 0;
         dwell = '0;
         foreach (windows[k]) windows[k] = '0;
         held = LANDSCAPE;
         change_at = '0;
         mismatches = 0;
      endfunction

      function bit covers(window_type w, axis_type x, axis_type y);
         return w[WIN_W-1] && x >= w[SBITS-1:0] && x <= w[2*SBITS-1:SBITS]
            && y >= w[3*SBITS-1:2*SBITS] && y <= w[4*SBITS-1:3*SBITS];
      endfunction

      function void note_setting(csr_index_type idx, window_type data);
         if (idx == CSR_AUTO_ENABLE) begin
            auto_on = data[0];
         end else if (idx == CSR_DWELL_MS) begin
            dwell = data[DWELL_W-1:0];
         end else if (idx >= CSR_WINDOW_BASE && idx < CSR_FIRST_SPARE) begin
            windows[idx - CSR_WINDOW_BASE] = data;
         end
      endfunction

      function void note_poll(axis_type x, axis_type y, stamp_type now);
         verdict_type v;
         stamp_type   elapsed;
         v = '0;
         if (auto_on) begin
            // windows in index order; a later hit may still move the candidate
            for (int k = 0; k < ORIENTS; k++) begin
               elapsed = now - change_at;
               if (!covers(windows[k], x, y)) continue;
               if (k == held) begin
                  if (elapsed > dwell) begin
                     v.rotate_now = 1'b1;
                     v.rotate_to  = 2'(k);
                  end
               end else begin
                  held = 2'(k);
                  change_at = now;
                  v.timer_restarted = 1'b1;
               end
            end
         end
         v.candidate = held;
         due_verdicts.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (due_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with nothing outstanding: rotate_now=%0d rotate_to=%0d",
                        $realtime, got.rotate_now, got.rotate_to);
            return;
         end
         want = due_verdicts.pop_front();
         if (got.rotate_now !== want.rotate_now || got.rotate_to !== want.rotate_to
             || got.candidate !== want.candidate
             || got.timer_restarted !== want.timer_restarted) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("%0t: mismatch rotate_now %0d/%0d rotate_to %0d/%0d",
                      $realtime, want.rotate_now, got.rotate_now, want.rotate_to,
                      got.rotate_to);
               $display(" candidate %0d/%0d restarted %0d/%0d (exp/act)",
                        want.candidate, got.candidate,
                        want.timer_restarted, got.timer_restarted);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tod_req_if req_bus ();
   tod_rsp_if rsp_bus ();
   tod_csr_if csr_bus ();

   tilt_orientation_dwell_detector_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   dwell_checker chk;

   bit        offering;       // request valid currently held high
   int        burst_left;     // requests left in the current sender burst
   bit        hold_request;   // asks the receiver for a long hold-off
   stamp_type poll_ms;        // running timestamp for random polls
   int        run_left;
   int        run_target;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #1_000_000;
      $display("tilt_orientation_dwell_detector_core test failed");
      $finish;
   end

   // Response side: ready follows a mode that is redrawn at random after a random-length run,
   // with a long hold-off on request so the pipe fills and stalls its input.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          held_off;
      logic [1:0]  beat;
      rsp_bus.ready = 1'b0;
      mode = RX_STREAM;
      mode_left = 0;
      held_off = 0;
      beat = '0;
      forever begin
         @(posedge clock);
         beat++;
         if (hold_request) begin
            hold_request = 0;
            held_off = HOLD_CYCLES;
         end
         if (held_off > 0) begin
            held_off--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(RX_RARE_STALL, RX_STREAM));
               mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            case (mode)
               RX_STREAM:      rsp_bus.ready <= 1'b1;
               RX_COIN:        rsp_bus.ready <= 1'($urandom_range(1, 0));
               RX_ONE_IN_FOUR: rsp_bus.ready <= (beat == 2'd0);
               default:        rsp_bus.ready <= ($urandom_range(9, 0) != 0);
            endcase
         end
      end
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         chk.check_verdict('{rotate_now: rsp_bus.rotate_now, rotate_to: rsp_bus.rotate_to,
                             candidate: rsp_bus.candidate,
                             timer_restarted: rsp_bus.timer_restarted});
   end

   function automatic window_type rand41();
      window_type r;
      r = window_type'({$urandom, $urandom});
      return r;
   endfunction

   // Random window: mostly well-ordered and enabled, some disabled,
   // some left as drawn so min can end up above max.
   function automatic window_type make_window();
      axis_type a, b, c, d, t;
      int       pick;
      a = axis_type'($urandom);
      b = axis_type'($urandom);
      c = axis_type'($urandom);
      d = axis_type'($urandom);
      pick = $urandom_range(9, 0);
      if (pick < 8) begin
         if (a > b) begin t = a; a = b; b = t; end
         if (c > d) begin t = c; c = d; d = t; end
      end
      return {(pick != 0), d, c, b, a};
   endfunction

   // CSR write; valid stays up so back-to-back writes need no drop in between.
   task automatic set_reg(csr_index_type idx, window_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      chk.note_setting(idx, data);
   endtask

   // Full register set, plus one write to an unused index.
   task automatic program_regs(window_type auto_word, window_type dwell_word,
                               window_type wins[ORIENTS]);
      set_reg(CSR_AUTO_ENABLE, auto_word);
      set_reg(CSR_DWELL_MS, dwell_word);
      for (int k = 0; k < ORIENTS; k++)
         set_reg(csr_index_type'(CSR_WINDOW_BASE + k), wins[k]);
      set_reg(csr_index_type'($urandom_range((1 << CSR_IDX_W) - 1, CSR_FIRST_SPARE)),
              rand41());
      csr_bus.valid <= 1'b0;
   endtask

   // One request. The sender runs in bursts; between bursts valid drops for
   // a random gap. Long bursts give stretches with no idling at all.
   task automatic send_poll(axis_type x, axis_type y, stamp_type t);
      if (!offering) begin
         repeat ($urandom_range(8, 1)) @(posedge clock);
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
         offering = 1;
      end
      req_bus.valid    <= 1'b1;
      req_bus.sample_x <= x;
      req_bus.sample_y <= y;
      req_bus.time_ms  <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      chk.note_poll(x, y, t);
      burst_left--;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         offering = 0;
      end
   endtask

   // Stop offering and wait out every outstanding response, plus the pipe depth.
   task automatic settle();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 0;
      end
      while (chk.due_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random poll: mostly runs of samples inside one window with time moving
   // in steps scaled to the dwell, so candidates settle and then rotate.
   // The rest are corners, uniform noise, random time jumps and polls that
   // land right at the dwell boundary.
   task automatic random_poll();
      axis_type   x, y;
      window_type w;
      int         pick;
      if (run_left == 0) begin
         run_target = $urandom_range(ORIENTS - 1, 0);
         run_left = $urandom_range(10, 2);
      end
      run_left--;
      w = chk.windows[run_target];
      pick = $urandom_range(99, 0);
      if (pick < 80 && w[SBITS-1:0] <= w[2*SBITS-1:SBITS]
          && w[3*SBITS-1:2*SBITS] <= w[4*SBITS-1:3*SBITS]) begin
         x = axis_type'($urandom_range(w[2*SBITS-1:SBITS], w[SBITS-1:0]));
         y = axis_type'($urandom_range(w[4*SBITS-1:3*SBITS], w[3*SBITS-1:2*SBITS]));
      end else if (pick < 90) begin
         x = $urandom_range(1, 0) ? AXIS_MAX : '0;
         y = $urandom_range(1, 0) ? AXIS_MAX : '0;
      end else begin
         x = axis_type'($urandom);
         y = axis_type'($urandom);
      end
      pick = $urandom_range(99, 0);
      if (pick < 8)
         poll_ms = $urandom;
      else if (pick < 18)
         poll_ms = chk.change_at + chk.dwell + $urandom_range(1, 0);
      else
         poll_ms = poll_ms + $urandom_range(chk.dwell / 3 + 2, 0);
      send_poll(x, y, poll_ms);
   endtask

   initial begin
      window_type wins[ORIENTS];
      window_type auto_word;
      window_type dwell_word;
      int         count;

      chk = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample_x = '0;
      req_bus.sample_y = '0;
      req_bus.time_ms = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      offering = 0;
      burst_left = 0;
      hold_request = 0;
      poll_ms = '0;
      run_left = 0;
      run_target = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: auto mode off, every request is a no-op.
      send_poll('0, '0, '0);
      send_poll(AXIS_MAX, AXIS_MAX, '1);
      settle();

      // Left and right halves overlapping in the middle, an inverted window
      // and a disabled full-range window.
      wins[LANDSCAPE]      = {1'b1, 10'd1023, 10'd0, 10'd511, 10'd0};
      wins[PORTRAIT]       = {1'b1, 10'd1023, 10'd0, 10'd1023, 10'd256};
      wins[LANDSCAPE_FLIP] = {1'b1, 10'd1023, 10'd0, 10'd0, 10'd1023};
      wins[PORTRAIT_FLIP]  = {1'b0, 10'd1023, 10'd0, 10'd1023, 10'd0};
      program_regs(AUTO_ON, window_type'(100), wins);

      // dwell boundary: equal elapsed holds, one more rotates
      send_poll('0, '0, 50);
      send_poll('0, '0, 100);
      send_poll('0, '0, 101);
      send_poll(AXIS_MAX, AXIS_MAX, 200);
      send_poll(AXIS_MAX, AXIS_MAX, 300);
      send_poll(AXIS_MAX, AXIS_MAX, 301);
      // overlap: rotate to the held candidate, then a later window takes over
      send_poll('0, '0, 2000);
      send_poll('0, '0, 2101);
      send_poll(10'd300, 10'd500, 2300);
      // elapsed time across the 32-bit wrap
      send_poll('0, '0, 32'hFFFF_FFC0);
      send_poll('0, '0, 32'h0000_0020);
      send_poll('0, '0, 32'h0000_0025);
      send_poll(AXIS_MAX, '0, 32'h0000_0030);
      send_poll('0, AXIS_MAX, 32'h0000_0200);
      settle();

      // auto mode off holds the candidate
      program_regs(AUTO_OFF, window_type'(100), wins);
      send_poll(AXIS_MAX, AXIS_MAX, 32'h0000_1000);
      settle();

      // zero dwell: rotates one ms after the candidate settles
      program_regs(AUTO_ON, window_type'(0), wins);
      send_poll('0, '0, 32'h0000_1000);
      send_poll(AXIS_MAX, AXIS_MAX, 32'h0000_2000);
      send_poll(AXIS_MAX, AXIS_MAX, 32'h0000_2000);
      send_poll(AXIS_MAX, AXIS_MAX, 32'h0000_2001);
      settle();

      // longest dwell
      program_regs(AUTO_ON, window_type'(16'hFFFF), wins);
      send_poll('0, '0, 32'h0000_3000);
      send_poll('0, '0, 32'h0000_3000 + 65535);
      send_poll('0, '0, 32'h0000_3000 + 65536);

      // Random phases. Upper data bits are junk on the narrow registers.
      for (int p = 0; p < 8; p++) begin
         settle();
         foreach (wins[k]) wins[k] = make_window();
         auto_word = rand41();
         auto_word[0] = (p != 2);
         dwell_word = rand41();
         dwell_word[DWELL_W-1:0] = dwell_type'($urandom_range(3000, 1));
         poll_ms = $urandom;
         case (p)
            0: dwell_word[DWELL_W-1:0] = '0;
            1: dwell_word[DWELL_W-1:0] = '1;
            3: begin
               // disjoint quadrants
               wins[LANDSCAPE]      = {1'b1, 10'd511, 10'd0, 10'd511, 10'd0};
               wins[PORTRAIT]       = {1'b1, 10'd511, 10'd0, 10'd1023, 10'd512};
               wins[LANDSCAPE_FLIP] = {1'b1, 10'd1023, 10'd512, 10'd511, 10'd0};
               wins[PORTRAIT_FLIP]  = {1'b1, 10'd1023, 10'd512, 10'd1023, 10'd512};
            end
            4: poll_ms = 32'hFFFF_F000 - $urandom_range(4000, 0);
            5: foreach (wins[k]) wins[k] = '1;
            default: ;
         endcase
         program_regs(auto_word, dwell_word, wins);
         // long receiver hold-off while requests keep coming
         if (p == 3 || p == 6) hold_request = 1;
         count = (p == 2) ? 40 : 140;
         run_left = 0;
         repeat (count) random_poll();
      end

      settle();
      if (chk.mismatches == 0 && chk.due_verdicts.size() == 0) begin
         $display("tilt_orientation_dwell_detector_core test passed");
      end else begin
         $display("tilt_orientation_dwell_detector_core test failed");
      end
      $finish;
   end

endmodule
